[hdl/kvt_pkg.sv]
// Shared types, constants and status codes for the key/value table.
package kvt_pkg;

	// Number of table slots, one cell each
	localparam int unsigned ENTRIES = 16;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DUP      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Reserved key that marks an empty slot
	localparam logic [KEY_W-1:0] KEY_EMPTY = '0;

	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} kvt_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] found_value;
	} kvt_out_t;

	// Request token that walks the chain of cells
	typedef struct packed {
		logic     valid;
		logic     done;
		kvt_in_t  req;
		kvt_out_t res;
	} kvt_tok_t;

endpackage

[hdl/key_value_table_unit.sv]
// Top level of the key/value table: request entry, chain of slot cells, result register.
//
//  channel   signals                 direction  transfer when
//  request   start, busy, req        in         start && !busy at clk edge
//  result    done, result            out        every cycle done is high
//
// From the transfer to the done strobe an operation passes the entry
// register, one register per slot cell as the token walks the chain, and
// the result register. busy is high from the transfer until the done cycle;
// a new request can transfer in the cycle that done is shown.
// Reset empties every slot at once; the receiver cannot stall results.
module key_value_table_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kvt_pkg::kvt_in_t  req,
	output logic              done,
	output kvt_pkg::kvt_out_t result
);
	import kvt_pkg::*;

	kvt_tok_t chain [0:ENTRIES];
	kvt_tok_t entry_d;
	kvt_tok_t entry_q;
	kvt_tok_t tail;
	kvt_out_t result_d;
	kvt_out_t result_q;
	logic     busy_q;
	logic     done_q;
	logic     accept;

	assign accept = start && !busy_q;

	// Build the token; the reserved key is resolved without a scan
	always_comb begin
		entry_d.valid           = accept;
		entry_d.req             = req;
		entry_d.done            = (req.key == KEY_EMPTY);
		entry_d.res.found_value = '0;
		if (req.operation == OP_SEARCH) begin
			entry_d.res.status = ST_NOTFOUND;
		end else begin
			entry_d.res.status = ST_DUP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign chain[0] = entry_q;

	// Row of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (chain[i]),
			.tok_o (chain[i+1])
		);
	end

	assign tail = chain[ENTRIES];

	// Close out a token that passed every slot unresolved
	always_comb begin
		result_d = tail.res;
		if (!tail.done) begin
			result_d.found_value = '0;
			if (tail.req.operation == OP_SEARCH) begin
				result_d.status = ST_NOTFOUND;
			end else begin
				result_d.status = ST_FULL;
			end
		end
	end

	// Track the operation in flight and strobe its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			result_q <= result_d;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

[hdl/kvt_cell.sv]
// One table slot: holds a key/value pair and serves the token passing through.
module kvt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  kvt_pkg::kvt_tok_t tok_i,
	output kvt_pkg::kvt_tok_t tok_o
);
	import kvt_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	kvt_tok_t         tok_q;
	kvt_tok_t         tok_d;
	logic             hit;
	logic             empty;
	logic             write_en;

	// Match and empty checks; reserved key was resolved before the chain
	assign hit   = tok_i.valid && !tok_i.done && (key_q == tok_i.req.key);
	assign empty = tok_i.valid && !tok_i.done && (key_q == KEY_EMPTY);
	// Slots fill from the bottom and never empty, so the first empty slot
	// seen ends the scan: every occupied slot was already checked
	assign write_en = empty && !hit && (tok_i.req.operation == OP_INSERT);

	// Resolve the token in this slot when it matches or reaches free space
	always_comb begin
		tok_d = tok_i;
		if (hit) begin
			tok_d.done = 1'b1;
			if (tok_i.req.operation == OP_SEARCH) begin
				tok_d.res.status      = ST_OK;
				tok_d.res.found_value = value_q;
			end else begin
				tok_d.res.status = ST_DUP;
			end
		end else if (empty) begin
			tok_d.done = 1'b1;
			if (tok_i.req.operation == OP_SEARCH) begin
				tok_d.res.status = ST_NOTFOUND;
			end else begin
				tok_d.res.status = ST_OK;
			end
		end
	end

	// Hold the stored key; it defines whether the slot is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_EMPTY;
		end else if (write_en) begin
			key_q <= tok_i.req.key;
		end
	end

	// Store the value together with its key
	always_ff @(posedge clk) begin
		if (write_en) begin
			value_q <= tok_i.req.value;
		end
	end

	// Advance the token to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

[hdl/kvt_checker.sv]
// Port-level checks for the key/value table, bound to the top level.
module kvt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input kvt_pkg::kvt_in_t  req,
	input logic              done,
	input kvt_pkg::kvt_out_t result
);
	import kvt_pkg::*;

	// A transfer marks the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request transfer");

	// The result cycle ends the busy period
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy high while result is strobed");

	// One result per operation: strobes never run back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobed in two consecutive cycles");

	// A value is returned only on success
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.found_value == '0))
		else $error("nonzero value with failing status");

	// A reserved-key search never succeeds
	a_zero_search: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == OP_SEARCH && req.key == KEY_EMPTY)
		|-> ##(ENTRIES + 2) (done && result.status == ST_NOTFOUND))
		else $error("search for reserved key did not report not found");

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.result(result)
);

[tb/key_value_table_unit_tb.sv]
// Self-checking testbench for the key/value table: directed rows, then random traffic.
module key_value_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kvt_pkg::*;

	localparam int RAND_ITEMS     = 630;
	localparam int QUIET_TAIL     = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = ENTRIES + 6;
	localparam int REPORT_MAX     = 10;
	localparam int IN_W           = $bits(kvt_in_t);
	localparam int IDX_W          = $clog2(ENTRIES);

	typedef struct {
		kvt_in_t  item;
		bit       typed;
		kvt_out_t want;
	} directed_row_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	kvt_in_t  req    = '0;
	logic     busy;
	logic     done;
	kvt_out_t result;

	// Expectation typed into the directed table, travels with the request
	bit       want_typed = 1'b0;
	kvt_out_t want_fixed = '0;

	// Shadow copy of the table contents
	logic [KEY_W-1:0] slot_key [ENTRIES] = '{default: '0};
	logic [VAL_W-1:0] slot_val [ENTRIES] = '{default: '0};

	kvt_out_t expected_responses [$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int ins_stored     = 0;
	int ins_dup        = 0;
	int ins_full       = 0;
	int search_hit     = 0;
	int search_miss    = 0;

	key_value_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the shadow table and return its response
	function automatic kvt_out_t predict_table_op(input kvt_in_t item);
		kvt_out_t r;
		int       hit;
		int       hole;
		r.status      = ST_NOTFOUND;
		r.found_value = '0;
		hit  = -1;
		hole = -1;
		for (int s = 0; s < ENTRIES; s++) begin
			if (item.key != KEY_EMPTY && slot_key[s] == item.key && hit < 0)
				hit = s;
			if (slot_key[s] == KEY_EMPTY && hole < 0)
				hole = s;
		end
		if (item.operation == OP_INSERT) begin
			if (item.key == KEY_EMPTY || hit >= 0) begin
				r.status = ST_DUP;
			end else if (hole < 0) begin
				r.status = ST_FULL;
			end else begin
				slot_key[hole] = item.key;
				slot_val[hole] = item.value;
				r.status       = ST_OK;
			end
		end else if (hit >= 0) begin
			r.status      = ST_OK;
			r.found_value = slot_val[hit];
		end
		return r;
	endfunction

	function automatic directed_row_t make_row(input logic op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, input bit typed, input logic [1:0] st,
			input logic [VAL_W-1:0] fv);
		directed_row_t row;
		row.item.operation    = op;
		row.item.key          = key;
		row.item.value        = val;
		row.typed             = typed;
		row.want.status       = st;
		row.want.found_value  = fv;
		return row;
	endfunction

	// Mostly hits and duplicates on live keys; some misses, new-key inserts and reserved keys
	function automatic kvt_in_t random_op();
		kvt_in_t it;
		int      pick;
		it.value     = $urandom;
		it.key       = $urandom;
		it.operation = $urandom_range(1) ? OP_SEARCH : OP_INSERT;
		pick         = $urandom_range(99);
		if (pick < 40) begin
			it.operation = OP_SEARCH;
			it.key       = slot_key[IDX_W'($urandom_range(ENTRIES-1))];
		end else if (pick < 55) begin
			it.operation = OP_SEARCH;
		end else if (pick < 70) begin
			it.operation = OP_INSERT;
			it.key       = slot_key[IDX_W'($urandom_range(ENTRIES-1))];
		end else if (pick < 85) begin
			it.operation = OP_INSERT;
		end else if (pick < 90) begin
			it.key = KEY_EMPTY;
		end else if (pick < 95) begin
			it.key = '1;
		end else begin
			it.key = KEY_W'(1) << $urandom_range(KEY_W-1);
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// Present one request and hold it until the transfer
	task automatic send_op(input kvt_in_t item, input bit typed, input kvt_out_t want);
		@(negedge clk);
		start      <= 1'b1;
		req        <= item;
		want_typed <= typed;
		want_fixed <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Drop start for a burst of cycles, with noise on the request bus
	task automatic idle_burst(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		req   <= IN_W'({$urandom, $urandom, $urandom});
		repeat (cycles - 1) begin
			@(negedge clk);
			req <= IN_W'({$urandom, $urandom, $urandom});
		end
	endtask

	// Check results, record transfers, watch for a stalled run
	always @(posedge clk) begin
		kvt_out_t want;
		kvt_out_t pred;
		bit       moved;
		if (arst_n) begin
			moved = 1'b0;
			if (done === 1'b1) begin
				moved = 1'b1;
				if (expected_responses.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: status %0d value %h",
						result.status, result.found_value));
				end else begin
					want = expected_responses.pop_front();
					if (result.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, result.status));
					if (result.found_value !== want.found_value)
						report_mismatch($sformatf("found_value expected %h got %h",
							want.found_value, result.found_value));
				end
			end
			if (start && busy === 1'b0) begin
				moved = 1'b1;
				pred  = predict_table_op(req);
				if (req.operation == OP_INSERT) begin
					if (pred.status == ST_OK)
						ins_stored++;
					else if (pred.status == ST_DUP)
						ins_dup++;
					else
						ins_full++;
				end else if (pred.status == ST_OK) begin
					search_hit++;
				end else begin
					search_miss++;
				end
				expected_responses.push_back(want_typed ? want_fixed : pred);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", idle_cycles);
				$display("[key_value_table_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t rows [$];
		// Empty table, reserved key, first inserts at both extremes
		rows.push_back(make_row(OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND,
			'0));
		rows.push_back(make_row(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_NOTFOUND,
			'0));
		rows.push_back(make_row(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_DUP, '0));
		rows.push_back(make_row(OP_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_OK, '0));
		rows.push_back(make_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, '0));
		rows.push_back(make_row(OP_SEARCH, 32'h0000_0001, 32'hA5A5_A5A5, 1'b1, ST_OK, '0));
		rows.push_back(make_row(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,
			32'hFFFF_FFFF));
		// Duplicate insert keeps the old value
		rows.push_back(make_row(OP_INSERT, 32'h0000_0001, 32'h1234_5678, 1'b1, ST_DUP, '0));
		rows.push_back(make_row(OP_SEARCH, 32'h0000_0001, 32'h0000_0000, 1'b1, ST_OK, '0));
		rows.push_back(make_row(OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOTFOUND,
			'0));
		// Fill the remaining slots
		for (int i = 0; i < ENTRIES - 2; i++)
			rows.push_back(make_row(OP_INSERT, {4'(i + 2), 28'($urandom)}, $urandom,
				1'b0, ST_OK, '0));
		// Table full rejects a new key
		rows.push_back(make_row(OP_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b1, ST_FULL, '0));

		// Hold reset, then release on a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_op(rows[i].item, rows[i].typed, rows[i].want);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n < RAND_ITEMS - QUIET_TAIL && (n / 64) % 3 != 2 && $urandom_range(3) == 0)
				idle_burst($urandom_range(1, 15));
			send_op(random_op(), 1'b0, '0);
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain pending results, then watch for strays
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("inserts: %0d stored, %0d duplicate or reserved key, %0d rejected as full",
			ins_stored, ins_dup, ins_full);
		$display("searches: %0d hits, %0d misses; %0d mismatches", search_hit, search_miss,
			mismatch_count);
		if (mismatch_count == 0)
			$display("[key_value_table_unit] OK");
		else
			$display("[key_value_table_unit] ERROR");
		$finish;
	end

endmodule
